// File: rtl/pqcp_pkg.sv
package pqcp_pkg;

  // Fixed field widths of one packet header and one result.
  localparam int unsigned TIME_BITS       = 48;
  localparam int unsigned PORT_W          = 4;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned THR_W           = 24;
  localparam int unsigned XON_W           = 25;
  localparam int unsigned SIZE_W          = 16;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned RATE_W          = 32;
  localparam int unsigned MIN_FRAME_BYTES = 84;

  // Stream and register port widths.
  localparam int unsigned IN_TDATA_W  = 152;
  localparam int unsigned IN_TUSER_W  = 5;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned APB_ADDR_W  = 5;
  localparam int unsigned APB_DATA_W  = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_REQUEST   = 3'd0,
    KIND_REPLY     = 3'd1,
    KIND_GRANT     = 3'd2,
    KIND_GRANT_REQ = 3'd3,
    KIND_RESEND    = 3'd4,
    KIND_OTHER     = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_MARK   = 3'd1,
    REG_XOFF   = 3'd2,
    REG_XON    = 3'd3,
    REG_RATE   = 3'd4
  } reg_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_tick;
    logic [PORT_W-1:0]    in_port;
    logic [PORT_W-1:0]    out_port;
    logic                 is_udp;
    logic [KIND_W-1:0]    msg_kind;
    logic                 was_bounced;
    logic                 unsolicited;
    logic [THR_W-1:0]     credit_bytes;
    logic [SIZE_W-1:0]    pkt_bytes;
    logic [THR_W-1:0]     in_queue_bytes;
    logic [THR_W-1:0]     out_queue_bytes;
  } item_t;

  typedef struct packed {
    logic              bounce;
    logic [PORT_W-1:0] egress_port;
    logic              ce_mark;
    logic              egress_paused;
    logic [CNT_W-1:0]  egress_phantom_bytes;
  } res_t;

  // Register values as seen by the datapath; xoff and xon are already resolved.
  typedef struct packed {
    logic              enable;
    logic [THR_W-1:0]  mark_thr;
    logic [THR_W-1:0]  xoff;
    logic [THR_W-1:0]  xon;
    logic [RATE_W-1:0] rate;
  } cfg_t;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  // XOFF/XON hysteresis on the larger of the phantom count and the real queue.
  function automatic logic pause_next(logic paused, logic [CNT_W-1:0] cnt,
                                      logic [THR_W-1:0] q, logic [THR_W-1:0] xoff,
                                      logic [THR_W-1:0] xon);
    logic [CNT_W-1:0] m;
    logic             r;
    m = (cnt > CNT_W'(q)) ? cnt : CNT_W'(q);
    r = paused;
    if (xoff != '0) begin
      if (!paused && (m > CNT_W'(xoff))) begin
        r = 1'b1;
      end else if (paused && (m < CNT_W'(xon))) begin
        r = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/pqcp_drain.sv
module pqcp_drain (
  input  logic [pqcp_pkg::TIME_BITS-1:0] now_i,
  input  logic [pqcp_pkg::TIME_BITS-1:0] last_i,
  input  logic [pqcp_pkg::RATE_W-1:0]    rate_i,
  output logic [pqcp_pkg::CNT_W-1:0]     amount_o,
  output logic                           sat_o
);

  localparam int unsigned HALF_W = pqcp_pkg::RATE_W / 2;
  localparam int unsigned PW     = pqcp_pkg::TIME_BITS + HALF_W;

  logic [pqcp_pkg::TIME_BITS-1:0] elapsed;
  logic [PW-1:0]                  hi_prod;
  logic [PW-1:0]                  lo_prod;
  logic [PW:0]                    sum;

  // A zero last tick means the port was never drained.
  assign elapsed = ((last_i == '0) || (now_i < last_i)) ? '0 : now_i - last_i;

  // The Q16.16 rate is split in halves so each product stays a narrow multiply.
  assign hi_prod = elapsed * rate_i[pqcp_pkg::RATE_W-1:HALF_W];
  assign lo_prod = elapsed * rate_i[HALF_W-1:0];
  assign sum     = {1'b0, hi_prod} + (PW+1)'(lo_prod >> HALF_W);

  assign amount_o = sum[pqcp_pkg::CNT_W-1:0];
  assign sat_o    = |sum[PW:pqcp_pkg::CNT_W];

endmodule

// File: rtl/pqcp_cfg.sv
module pqcp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pqcp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pqcp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pqcp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output pqcp_pkg::cfg_t                  cfg_o
);

  logic                           en_q, en_d;
  logic [pqcp_pkg::THR_W-1:0]     mark_q, mark_d;
  logic [pqcp_pkg::THR_W-1:0]     xoff_q, xoff_d;
  logic [pqcp_pkg::XON_W-1:0]     xon_q, xon_d;
  logic [pqcp_pkg::RATE_W-1:0]    rate_q, rate_d;
  logic [pqcp_pkg::THR_W-1:0]     xoff_eff_q, xoff_eff_d;
  logic [pqcp_pkg::THR_W-1:0]     xon_eff_q, xon_eff_d;
  logic                           wr;
  pqcp_pkg::reg_e                 idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = pqcp_pkg::reg_e'(paddr[4:2]);

  always_comb begin
    en_d   = en_q;
    mark_d = mark_q;
    xoff_d = xoff_q;
    xon_d  = xon_q;
    rate_d = rate_q;
    if (wr) begin
      unique case (idx)
        pqcp_pkg::REG_ENABLE: en_d   = pwdata[0];
        pqcp_pkg::REG_MARK:   mark_d = pwdata[pqcp_pkg::THR_W-1:0];
        pqcp_pkg::REG_XOFF:   xoff_d = pwdata[pqcp_pkg::THR_W-1:0];
        pqcp_pkg::REG_XON:    xon_d  = pwdata[pqcp_pkg::XON_W-1:0];
        pqcp_pkg::REG_RATE:   rate_d = pwdata[pqcp_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Resolve the effective pause levels at write time, off the packet path.
  always_comb begin
    xoff_eff_d = (xoff_d != '0) ? xoff_d : mark_d;
    if (xon_d[pqcp_pkg::XON_W-1]) begin
      xon_eff_d = (xoff_eff_d > pqcp_pkg::THR_W'(pqcp_pkg::MIN_FRAME_BYTES)) ?
                  xoff_eff_d - pqcp_pkg::THR_W'(pqcp_pkg::MIN_FRAME_BYTES) : '0;
    end else begin
      xon_eff_d = xon_d[pqcp_pkg::THR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      mark_q     <= '0;
      xoff_q     <= '0;
      xon_q      <= '1;
      rate_q     <= '0;
      xoff_eff_q <= '0;
      xon_eff_q  <= '0;
    end else begin
      en_q       <= en_d;
      mark_q     <= mark_d;
      xoff_q     <= xoff_d;
      xon_q      <= xon_d;
      rate_q     <= rate_d;
      xoff_eff_q <= xoff_eff_d;
      xon_eff_q  <= xon_eff_d;
    end
  end

  always_comb begin
    unique case (idx)
      pqcp_pkg::REG_ENABLE: prdata = pqcp_pkg::APB_DATA_W'(en_q);
      pqcp_pkg::REG_MARK:   prdata = pqcp_pkg::APB_DATA_W'(mark_q);
      pqcp_pkg::REG_XOFF:   prdata = pqcp_pkg::APB_DATA_W'(xoff_q);
      pqcp_pkg::REG_XON:    prdata = pqcp_pkg::APB_DATA_W'(xon_q);
      pqcp_pkg::REG_RATE:   prdata = rate_q;
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.enable   = en_q;
  assign cfg_o.mark_thr = mark_q;
  assign cfg_o.xoff     = xoff_eff_q;
  assign cfg_o.xon      = xon_eff_q;
  assign cfg_o.rate     = rate_q;

endmodule

// File: rtl/pqcp_engine.sv
module pqcp_engine #(
  parameter int unsigned NUM_PORTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           proc_i,
  input  pqcp_pkg::item_t item_i,
  input  pqcp_pkg::cfg_t  cfg_i,
  output pqcp_pkg::res_t  res_o
);

  localparam int unsigned IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int unsigned CMP_W = 9;

  logic [pqcp_pkg::CNT_W-1:0]     phantom_q [NUM_PORTS];
  logic [pqcp_pkg::TIME_BITS-1:0] last_q    [NUM_PORTS];
  logic [NUM_PORTS-1:0]           paused_q;

  logic [IDX_W-1:0]               ip_idx, op_idx, ep_idx;
  logic                           ip_ok, op_ok, en_ok;
  logic                           grant, grant_fresh, bounced, same_port;
  logic                           pa1, pa2, e_pa, pa3, ce;
  logic [pqcp_pkg::CNT_W-1:0]     p_ip, p_ip2, e_ph, d_ph, f_ph, m;
  logic [pqcp_pkg::THR_W-1:0]     eq;
  logic [pqcp_pkg::CNT_W-1:0]     amt_ip, amt_op, amt;
  logic                           sat_ip, sat_op, sat;
  logic                           adds, is_data;

  assign ip_idx = IDX_W'(item_i.in_port);
  assign op_idx = IDX_W'(item_i.out_port);
  assign ip_ok  = CMP_W'(item_i.in_port) < CMP_W'(NUM_PORTS);
  assign op_ok  = CMP_W'(item_i.out_port) < CMP_W'(NUM_PORTS);
  assign en_ok  = cfg_i.enable && item_i.is_udp && ip_ok && op_ok;

  // Drain amounts for both candidate egress ports, ahead of the bounce decision.
  pqcp_drain u_drain_ip (
    .now_i    (item_i.now_tick),
    .last_i   (last_q[ip_idx]),
    .rate_i   (cfg_i.rate),
    .amount_o (amt_ip),
    .sat_o    (sat_ip)
  );

  pqcp_drain u_drain_op (
    .now_i    (item_i.now_tick),
    .last_i   (last_q[op_idx]),
    .rate_i   (cfg_i.rate),
    .amount_o (amt_op),
    .sat_o    (sat_op)
  );

  always_comb begin
    grant       = item_i.msg_kind == pqcp_pkg::KIND_GRANT;
    grant_fresh = grant && !item_i.was_bounced;

    // Ingress on the arrival port.
    p_ip    = phantom_q[ip_idx];
    pa1     = pqcp_pkg::pause_next(paused_q[ip_idx], p_ip, item_i.in_queue_bytes,
                                   cfg_i.xoff, cfg_i.xon);
    bounced = grant_fresh && pa1;
    p_ip2   = (grant_fresh && !pa1) ?
              pqcp_pkg::sat_add(p_ip, pqcp_pkg::CNT_W'(item_i.credit_bytes)) : p_ip;
    pa2     = bounced ? pa1 :
              pqcp_pkg::pause_next(pa1, p_ip2, item_i.in_queue_bytes, cfg_i.xoff, cfg_i.xon);

    // Egress sees the ingress result when it lands on the same port.
    same_port = bounced || (item_i.in_port == item_i.out_port);
    ep_idx    = bounced ? ip_idx : op_idx;
    e_ph      = same_port ? p_ip2 : phantom_q[op_idx];
    e_pa      = same_port ? pa2 : paused_q[op_idx];
    eq        = bounced ? item_i.in_queue_bytes : item_i.out_queue_bytes;
    amt       = bounced ? amt_ip : amt_op;
    sat       = bounced ? sat_ip : sat_op;
    d_ph      = (sat || (amt >= e_ph)) ? '0 : e_ph - amt;

    adds = grant || item_i.unsolicited ||
           (item_i.msg_kind == pqcp_pkg::KIND_GRANT_REQ) ||
           (item_i.msg_kind == pqcp_pkg::KIND_RESEND);
    if (grant && item_i.was_bounced) begin
      f_ph = (pqcp_pkg::CNT_W'(item_i.credit_bytes) > d_ph) ?
             '0 : d_ph - pqcp_pkg::CNT_W'(item_i.credit_bytes);
    end else if (adds) begin
      f_ph = pqcp_pkg::sat_add(d_ph, pqcp_pkg::CNT_W'(item_i.pkt_bytes));
    end else begin
      f_ph = d_ph;
    end
    pa3 = pqcp_pkg::pause_next(e_pa, f_ph, eq, cfg_i.xoff, cfg_i.xon);

    is_data = (item_i.msg_kind == pqcp_pkg::KIND_REQUEST) ||
              (item_i.msg_kind == pqcp_pkg::KIND_REPLY) ||
              (item_i.msg_kind == pqcp_pkg::KIND_GRANT_REQ);
    m  = (f_ph > pqcp_pkg::CNT_W'(eq)) ? f_ph : pqcp_pkg::CNT_W'(eq);
    ce = is_data && (m > pqcp_pkg::CNT_W'(cfg_i.mark_thr));

    if (en_ok) begin
      res_o.bounce               = bounced;
      res_o.egress_port          = bounced ? item_i.in_port : item_i.out_port;
      res_o.ce_mark              = ce;
      res_o.egress_paused        = pa3;
      res_o.egress_phantom_bytes = f_ph;
    end else begin
      res_o.bounce               = 1'b0;
      res_o.egress_port          = item_i.out_port;
      res_o.ce_mark              = 1'b0;
      res_o.egress_paused        = op_ok ? paused_q[op_idx] : 1'b0;
      res_o.egress_phantom_bytes = op_ok ? phantom_q[op_idx] : '0;
    end
  end

  // Each port takes the egress update when it is the egress port, else the
  // ingress update when it is the arrival port, so the egress side wins when
  // both stages touch one port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paused_q <= '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        phantom_q[i] <= '0;
        last_q[i]    <= '0;
      end
    end else if (proc_i && en_ok) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        if (IDX_W'(i) == ep_idx) begin
          phantom_q[i] <= f_ph;
          paused_q[i]  <= pa3;
          last_q[i]    <= item_i.now_tick;
        end else if (IDX_W'(i) == ip_idx) begin
          phantom_q[i] <= p_ip2;
          paused_q[i]  <= pa2;
        end
      end
    end
  end

  a_bounce_fresh_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && res_o.bounce |-> en_ok && grant && !item_i.was_bounced)
    else $error("bounce on a packet that is not a fresh grant");

  a_drain_time_stamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && en_ok |=> last_q[$past(ep_idx)] == $past(item_i.now_tick))
    else $error("egress port drain time not updated");

  a_bypass_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && !en_ok |-> !res_o.ce_mark && !res_o.bounce &&
                         (res_o.egress_port == item_i.out_port))
    else $error("bypassed packet was modified");

endmodule

// File: rtl/phantom_queue_credit_pause.sv
// A header accepted on the slave side lands in the input register, is processed
// as it moves into the result register and is offered on the master side from
// there; it waits in the input register while a finished result is not taken.
// Throughput: one packet per cycle unless m_axis_tready holds results back; the
// per-port update and drain multiply form a single stage between the registers.
// Reset (rst_ni low, asynchronous) clears all phantom counts, drain ticks and
// pause flags, the config registers and both valid flags, but not the data registers.
module phantom_queue_credit_pause #(
  parameter int unsigned NUM_PORTS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  // Header stream in.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, lowest bit up: now_tick[47:0], in_port[51:48], out_port[55:52],
  // was_bounced[56], credit_bytes[80:57], pkt_bytes[96:81],
  // in_queue_bytes[120:97], out_queue_bytes[144:121], zero fill[151:145].
  input  logic [pqcp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser, lowest bit up: is_udp[0], msg_kind[3:1], unsolicited[4].
  input  logic [pqcp_pkg::IN_TUSER_W-1:0]  s_axis_tuser,

  // Result stream out.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, lowest bit up: bounce[0], egress_port[4:1], ce_mark[5],
  // egress_paused[6], egress_phantom_bytes[38:7], zero fill[39].
  output logic [pqcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,

  // Register port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pqcp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pqcp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pqcp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  pqcp_pkg::item_t in_item;
  pqcp_pkg::item_t s1_item_q;
  pqcp_pkg::res_t  res;
  pqcp_pkg::res_t  out_res_q;
  pqcp_pkg::cfg_t  cfg;

  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic s1_adv;
  logic s_fire;

  // Unpack the header transfer.
  assign in_item.now_tick        = s_axis_tdata[47:0];
  assign in_item.in_port         = s_axis_tdata[51:48];
  assign in_item.out_port        = s_axis_tdata[55:52];
  assign in_item.was_bounced     = s_axis_tdata[56];
  assign in_item.credit_bytes    = s_axis_tdata[80:57];
  assign in_item.pkt_bytes       = s_axis_tdata[96:81];
  assign in_item.in_queue_bytes  = s_axis_tdata[120:97];
  assign in_item.out_queue_bytes = s_axis_tdata[144:121];
  assign in_item.is_udp          = s_axis_tuser[0];
  assign in_item.msg_kind        = s_axis_tuser[3:1];
  assign in_item.unsolicited     = s_axis_tuser[4];

  // The result register frees up when it is empty or being taken this cycle.
  // The input register advances into it whenever it frees up; a new header
  // is still accepted while a result waits downstream if the input register is empty.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign s1_valid_d  = s_fire || (s1_valid_q && !out_free);
  assign out_valid_d = s1_adv || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  pqcp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Per-port state is read and written in the same cycle the header leaves
  // the input register, so back-to-back packets on one port see each other.
  pqcp_engine #(
    .NUM_PORTS (NUM_PORTS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .proc_i (s1_adv),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_res_q.egress_phantom_bytes,
                          out_res_q.egress_paused,
                          out_res_q.ce_mark,
                          out_res_q.egress_port,
                          out_res_q.bounce};

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s1_valid_q |-> s1_adv)
    else $error("header accepted over an occupied input register");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_valid_q))
    else $error("result appeared without a header in flight");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("waiting result changed before its transfer");

endmodule
